// ===== hdl/aef_pkg.sv =====
// ----------------------------------------------------------------------------
// aef_pkg
// types, codes and constants shared by the envelope follower modules
// ----------------------------------------------------------------------------
package aef_pkg;

    localparam int N_ENV   = 6;
    localparam int ENV_W   = 3;
    localparam int DT_W    = 10;
    localparam int DIV_NW  = 36;
    localparam int DIV_DW  = 16;
    localparam int DIV_MW  = 44;
    localparam int DIV_HW  = 18;
    localparam int DIV_SH  = 52;
    localparam int DIV_PPW = DIV_HW + DIV_MW;
    localparam int DIV_PW  = DIV_NW + DIV_MW;

    localparam logic [DT_W-1:0] DEFAULT_DT = 10'd16;
    localparam logic [15:0]     TEMPO_MIN  = 16'd262;

    localparam logic [63:0] ONE32 = 64'h1_0000_0000;

    // reciprocals for division by a constant, scaled by 2^52, rounded up
    localparam logic [63:0] RCP_ONE = 64'd1 << DIV_SH;
    localparam logic [DIV_MW-1:0] RCP_1000  = DIV_MW'((RCP_ONE + 64'd999) / 64'd1000);
    localparam logic [DIV_MW-1:0] RCP_1500  = DIV_MW'((RCP_ONE + 64'd1499) / 64'd1500);
    localparam logic [DIV_MW-1:0] RCP_4000  = DIV_MW'((RCP_ONE + 64'd3999) / 64'd4000);
    localparam logic [DIV_MW-1:0] RCP_8000  = DIV_MW'((RCP_ONE + 64'd7999) / 64'd8000);
    localparam logic [DIV_MW-1:0] RCP_10000 = DIV_MW'((RCP_ONE + 64'd9999) / 64'd10000);
    localparam logic [DIV_MW-1:0] RCP_20000 = DIV_MW'((RCP_ONE + 64'd19999) / 64'd20000);
    localparam logic [DIV_MW-1:0] RCP_60000 = DIV_MW'((RCP_ONE + 64'd59999) / 64'd60000);

    // per-ms decay factors, q0.32, from a five-term series of exp(-1/tau)
    localparam logic [63:0] X_300  = (ONE32 + 64'd150) / 64'd300;
    localparam logic [63:0] A2_300 = (X_300 * X_300) / (64'd2 * ONE32);
    localparam logic [63:0] A3_300 = (A2_300 * X_300) / (64'd3 * ONE32);
    localparam logic [63:0] A4_300 = (A3_300 * X_300) / (64'd4 * ONE32);
    localparam logic [63:0] R_300  = ONE32 - X_300 + A2_300 - A3_300 + A4_300;

    localparam logic [63:0] X_220  = (ONE32 + 64'd110) / 64'd220;
    localparam logic [63:0] A2_220 = (X_220 * X_220) / (64'd2 * ONE32);
    localparam logic [63:0] A3_220 = (A2_220 * X_220) / (64'd3 * ONE32);
    localparam logic [63:0] A4_220 = (A3_220 * X_220) / (64'd4 * ONE32);
    localparam logic [63:0] R_220  = ONE32 - X_220 + A2_220 - A3_220 + A4_220;

    localparam logic [63:0] X_450  = (ONE32 + 64'd225) / 64'd450;
    localparam logic [63:0] A2_450 = (X_450 * X_450) / (64'd2 * ONE32);
    localparam logic [63:0] A3_450 = (A2_450 * X_450) / (64'd3 * ONE32);
    localparam logic [63:0] A4_450 = (A3_450 * X_450) / (64'd4 * ONE32);
    localparam logic [63:0] R_450  = ONE32 - X_450 + A2_450 - A3_450 + A4_450;

    localparam logic [63:0] X_240  = (ONE32 + 64'd120) / 64'd240;
    localparam logic [63:0] A2_240 = (X_240 * X_240) / (64'd2 * ONE32);
    localparam logic [63:0] A3_240 = (A2_240 * X_240) / (64'd3 * ONE32);
    localparam logic [63:0] A4_240 = (A3_240 * X_240) / (64'd4 * ONE32);
    localparam logic [63:0] R_240  = ONE32 - X_240 + A2_240 - A3_240 + A4_240;

    localparam logic [63:0] X_200  = (ONE32 + 64'd100) / 64'd200;
    localparam logic [63:0] A2_200 = (X_200 * X_200) / (64'd2 * ONE32);
    localparam logic [63:0] A3_200 = (A2_200 * X_200) / (64'd3 * ONE32);
    localparam logic [63:0] A4_200 = (A3_200 * X_200) / (64'd4 * ONE32);
    localparam logic [63:0] R_200  = ONE32 - X_200 + A2_200 - A3_200 + A4_200;

    localparam logic [63:0] X_140  = (ONE32 + 64'd70) / 64'd140;
    localparam logic [63:0] A2_140 = (X_140 * X_140) / (64'd2 * ONE32);
    localparam logic [63:0] A3_140 = (A2_140 * X_140) / (64'd3 * ONE32);
    localparam logic [63:0] A4_140 = (A3_140 * X_140) / (64'd4 * ONE32);
    localparam logic [63:0] R_140  = ONE32 - X_140 + A2_140 - A3_140 + A4_140;

    localparam logic [31:0] DECAY_R [N_ENV] = '{
        R_300[31:0], R_220[31:0], R_450[31:0], R_240[31:0], R_200[31:0], R_140[31:0]
    };

    localparam logic [3:0] SLEW_RATE [N_ENV] = '{4'd6, 4'd7, 4'd5, 4'd7, 4'd7, 4'd8};

    typedef struct packed {
        logic        restart;
        logic [31:0] time_ms;
        logic [15:0] beat_decay;
        logic [15:0] onset_strength;
        logic [15:0] downbeat_strength;
        logic [15:0] kick_strength;
        logic [15:0] snare_strength;
        logic [15:0] hat_strength;
        logic [15:0] overall_level;
        logic [15:0] tempo_norm;
    } t_in;

    typedef struct packed {
        logic [15:0] beat_out;
        logic [15:0] onset_out;
        logic [15:0] downbeat_out;
        logic [15:0] kick_out;
        logic [15:0] snare_out;
        logic [15:0] hat_out;
        logic [31:0] motion_phase;
        logic [31:0] advance_phase;
        logic [15:0] swell_out;
        logic [15:0] beat_phase_out;
        logic [15:0] bar_phase_out;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_DEC_INIT, ST_DEC_STEP, ST_DEC_RND, ST_PEAK,
        ST_DIV_GO, ST_DIV_WAIT, ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_PREP, OP_DEC_INIT, OP_DEC_STEP, OP_DEC_RND,
        OP_PEAK, OP_DIV_GO, OP_DIV_PUT, OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        DS_SLEW, DS_MOTION, DS_ADV, DS_FAST, DS_SLOW, DS_BEAT, DS_BAR_MOD, DS_BAR
    } t_dsel;

    typedef struct packed {
        t_op   op;
        t_dsel dsel;
    } t_cmd;

    typedef struct packed {
        logic k_zero;
        logic last_env;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

// ===== hdl/aef_div.sv =====
// ----------------------------------------------------------------------------
// aef_div
// division by a constant through its scaled reciprocal, two partial products
// ----------------------------------------------------------------------------
module aef_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [aef_pkg::DIV_NW-1:0]   i_num,
    input  logic [aef_pkg::DIV_MW-1:0]   i_rcp,
    input  logic [aef_pkg::DIV_DW-1:0]   i_den,
    output logic                         o_busy,
    output logic [aef_pkg::DIV_NW-1:0]   o_quo,
    output logic [aef_pkg::DIV_DW-1:0]   o_rem
);
    import aef_pkg::*;

    logic [DIV_NW-1:0]               r_num;
    logic [DIV_MW-1:0]               r_rcp;
    logic [DIV_DW-1:0]               r_den;
    logic [DIV_PW-1:0]               r_acc;
    logic                            r_lo;
    logic                            r_busy;
    logic [DIV_HW-1:0]               part;
    logic [DIV_PPW-1:0]              pp;
    logic [DIV_PW-DIV_SH-1:0]        q;
    logic [DIV_PW-DIV_SH+DIV_DW-1:0] qd;
    logic [DIV_NW-1:0]               rem_full;

    // high half first, then shift and add the low half
    assign part     = r_lo ? r_num[DIV_HW-1:0] : r_num[DIV_NW-1:DIV_HW];
    assign pp       = DIV_PPW'(part) * DIV_PPW'(r_rcp);
    assign q        = r_acc[DIV_PW-1:DIV_SH];
    assign qd       = {{DIV_DW{1'b0}}, q} * {{(DIV_PW-DIV_SH){1'b0}}, r_den};
    assign rem_full = r_num - qd[DIV_NW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_lo   <= 1'b0;
            r_acc  <= '0;
            r_num  <= '0;
            r_rcp  <= '0;
            r_den  <= '0;
        end else if (i_start) begin
            r_num  <= i_num;
            r_rcp  <= i_rcp;
            r_den  <= i_den;
            r_acc  <= '0;
            r_lo   <= 1'b0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_acc <= {r_acc[DIV_PW-DIV_HW-1:0], {DIV_HW{1'b0}}} + DIV_PW'(pp);
            if (r_lo) begin
                r_busy <= 1'b0;
            end else begin
                r_lo <= 1'b1;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = DIV_NW'(q);
    assign o_rem  = rem_full[DIV_DW-1:0];

endmodule

// ===== hdl/aef_ctrl.sv =====
// ----------------------------------------------------------------------------
// aef_ctrl
// sequencer: steps the datapath through decay, peak, slew, level and phase updates
// ----------------------------------------------------------------------------
module aef_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  aef_pkg::t_stat i_stat,
    output aef_pkg::t_cmd  o_cmd
);
    import aef_pkg::*;

    t_state r_state, n_state;
    t_dsel  r_dsel, n_dsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dsel  <= DS_SLEW;
        end else begin
            r_state <= n_state;
            r_dsel  <= n_dsel;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_dsel     = r_dsel;
        o_cmd.op   = OP_NONE;
        o_cmd.dsel = r_dsel;
        o_stall    = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.op = OP_PREP;
                n_dsel   = DS_SLEW;
                n_state  = ST_DEC_INIT;
            end
            ST_DEC_INIT: begin
                o_cmd.op = OP_DEC_INIT;
                n_state  = ST_DEC_STEP;
            end
            ST_DEC_STEP: begin
                if (i_stat.k_zero) begin
                    n_state = ST_DEC_RND;
                end else begin
                    o_cmd.op = OP_DEC_STEP;
                end
            end
            ST_DEC_RND: begin
                o_cmd.op = OP_DEC_RND;
                n_state  = ST_PEAK;
            end
            ST_PEAK: begin
                o_cmd.op = OP_PEAK;
                n_state  = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                o_cmd.op = OP_DIV_GO;
                n_state  = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_DIV_PUT;
                    unique case (r_dsel)
                        DS_SLEW: begin
                            if (i_stat.last_env) begin
                                n_dsel  = DS_MOTION;
                                n_state = ST_DIV_GO;
                            end else begin
                                n_state = ST_DEC_INIT;
                            end
                        end
                        DS_BAR: begin
                            n_state = ST_EMIT;
                        end
                        default: begin
                            n_dsel  = t_dsel'(r_dsel + 3'd1);
                            n_state = ST_DIV_GO;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/aef_dp.sv =====
// ----------------------------------------------------------------------------
// aef_dp
// datapath: envelope state, shared multiplier, constant divider, output register
// ----------------------------------------------------------------------------
module aef_dp #(
    parameter int MAX_INTERVAL_MS = 250
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  aef_pkg::t_cmd  i_cmd,
    output aef_pkg::t_stat o_stat,
    input  aef_pkg::t_in   i_in_item,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output aef_pkg::t_out  o_out_item
);
    import aef_pkg::*;

    t_in              r_in;
    logic [DT_W-1:0]  r_dt;
    logic [31:0]      r_last;
    logic [15:0]      r_peak [N_ENV];
    logic [15:0]      r_slew [N_ENV];
    logic [31:0]      r_motion;
    logic [31:0]      r_adv;
    logic [15:0]      r_fast;
    logic [15:0]      r_slow;
    logic [15:0]      r_beat;
    logic [ENV_W-1:0] r_env;
    logic [DT_W-1:0]  r_k;
    logic [31:0]      r_acc;
    logic             r_dzero;
    logic [16:0]      r_d;
    logic [11:0]      r_barm;
    logic [15:0]      r_bar;
    t_out             r_out;
    logic             r_out_vld;

    logic [31:0]       last_eff;
    logic [31:0]       tdiff;
    logic [DT_W-1:0]   dt_calc;
    logic [15:0]       strength [N_ENV];
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       prod;
    logic [63:0]       acc_sum;
    logic [63:0]       dec_sum;
    logic [15:0]       dec;
    logic [15:0]       peak_new;
    logic [32:0]       acc_rnd;
    logic [13:0]       rate_dt;
    logic [19:0]       mot_base;
    logic [20:0]       adv_base;
    logic [23:0]       beat_base;
    logic              fup;
    logic              sup;
    logic [15:0]       fdiff;
    logic [15:0]       sdiff;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_MW-1:0] div_rcp;
    logic [DIV_DW-1:0] div_den;
    logic              div_busy;
    logic [DIV_NW-1:0] quo;
    logic [DIV_DW-1:0] rem;
    logic [15:0]       cur;
    logic [15:0]       tgt;
    logic              up;
    logic [15:0]       adiff;
    logic [15:0]       lim;
    logic [15:0]       slew_new;
    logic [17:0]       lvl_diff;
    logic [15:0]       swell;

    assign last_eff = r_in.restart ? 32'd0 : r_last;
    assign tdiff    = r_in.time_ms - last_eff;
    assign dt_calc  = (r_in.time_ms < last_eff || tdiff > 32'(MAX_INTERVAL_MS))
                      ? DEFAULT_DT : tdiff[DT_W-1:0];

    assign strength[0] = r_in.beat_decay;
    assign strength[1] = r_in.onset_strength;
    assign strength[2] = r_in.downbeat_strength;
    assign strength[3] = r_in.kick_strength;
    assign strength[4] = r_in.snare_strength;
    assign strength[5] = r_in.hat_strength;

    // one multiplier: decay power steps, then peak times decay
    assign mul_a    = (i_cmd.op == OP_PEAK) ? 32'(r_peak[r_env]) : r_acc;
    assign mul_b    = (i_cmd.op == OP_PEAK) ? 32'(r_d) : DECAY_R[r_env];
    assign prod     = 64'(mul_a) * 64'(mul_b);
    assign acc_sum  = prod + 64'h8000_0000;
    assign dec_sum  = prod + 64'd32768;
    assign dec      = (|dec_sum[63:32]) ? 16'hffff : dec_sum[31:16];
    assign peak_new = (dec > strength[r_env]) ? dec : strength[r_env];
    assign acc_rnd  = 33'(r_acc) + 33'd32768;

    assign rate_dt   = 14'(SLEW_RATE[r_env]) * 14'(r_dt);
    assign mot_base  = 20'd65536 + 20'(r_slew[0]) * 20'd5
                       + 20'(r_in.overall_level) * 20'd3;
    assign adv_base  = 21'd196608 + 21'(r_in.overall_level) * 21'd20;
    assign beat_base = 24'd2621440 + 24'(r_in.tempo_norm) * 24'd160;
    assign fup   = (r_in.overall_level >= r_fast);
    assign sup   = (r_in.overall_level >= r_slow);
    assign fdiff = fup ? r_in.overall_level - r_fast : r_fast - r_in.overall_level;
    assign sdiff = sup ? r_in.overall_level - r_slow : r_slow - r_in.overall_level;

    always_comb begin
        unique case (i_cmd.dsel)
            DS_SLEW: begin
                div_num = DIV_NW'({rate_dt, 16'd0}) + DIV_NW'(500);
                div_den = 16'd1000;
                div_rcp = RCP_1000;
            end
            DS_MOTION: begin
                div_num = DIV_NW'(mot_base) * DIV_NW'(r_dt) + DIV_NW'(5000);
                div_den = 16'd10000;
                div_rcp = RCP_10000;
            end
            DS_ADV: begin
                div_num = DIV_NW'(adv_base) * DIV_NW'(r_dt) + DIV_NW'(10000);
                div_den = 16'd20000;
                div_rcp = RCP_20000;
            end
            DS_FAST: begin
                div_num = DIV_NW'(fdiff) * DIV_NW'(r_dt) + DIV_NW'(750);
                div_den = 16'd1500;
                div_rcp = RCP_1500;
            end
            DS_SLOW: begin
                div_num = DIV_NW'(sdiff) * DIV_NW'(r_dt) + DIV_NW'(4000);
                div_den = 16'd8000;
                div_rcp = RCP_8000;
            end
            DS_BEAT: begin
                div_num = DIV_NW'(beat_base) * DIV_NW'(r_dt) + DIV_NW'(30000);
                div_den = 16'd60000;
                div_rcp = RCP_60000;
            end
            DS_BAR_MOD: begin
                div_num = DIV_NW'(r_in.time_ms);
                div_den = 16'd4000;
                div_rcp = RCP_4000;
            end
            DS_BAR: begin
                div_num = DIV_NW'({r_barm, 16'd0});
                div_den = 16'd4000;
                div_rcp = RCP_4000;
            end
            default: begin
                div_num = '0;
                div_den = 16'd1;
                div_rcp = '0;
            end
        endcase
    end

    aef_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV_GO),
        .i_num   (div_num),
        .i_rcp   (div_rcp),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (quo),
        .o_rem   (rem)
    );

    // slew toward the peak by at most the step limit
    assign cur      = r_slew[r_env];
    assign tgt      = r_peak[r_env];
    assign up       = (tgt >= cur);
    assign adiff    = up ? tgt - cur : cur - tgt;
    assign lim      = ({4'd0, adiff} > quo[19:0]) ? quo[15:0] : adiff;
    assign slew_new = up ? cur + lim : cur - lim;

    assign lvl_diff = {2'b00, r_fast} - {2'b00, r_slow};
    assign swell    = lvl_diff[17] ? 16'd0 :
                      (|lvl_diff[15:14]) ? 16'hffff : {lvl_diff[13:0], 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in      <= '0;
            r_dt      <= '0;
            r_last    <= '0;
            r_peak    <= '{default: '0};
            r_slew    <= '{default: '0};
            r_motion  <= '0;
            r_adv     <= '0;
            r_fast    <= '0;
            r_slow    <= '0;
            r_beat    <= '0;
            r_env     <= '0;
            r_k       <= '0;
            r_acc     <= '0;
            r_dzero   <= 1'b0;
            r_d       <= '0;
            r_barm    <= '0;
            r_bar     <= '0;
            r_out     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.op == OP_EMIT) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_in <= i_in_item;
                end
                OP_PREP: begin
                    r_dt   <= dt_calc;
                    r_last <= r_in.time_ms;
                    r_env  <= '0;
                    if (r_in.restart) begin
                        r_peak   <= '{default: '0};
                        r_slew   <= '{default: '0};
                        r_motion <= '0;
                        r_adv    <= '0;
                        r_fast   <= '0;
                        r_slow   <= '0;
                        r_beat   <= '0;
                    end
                end
                OP_DEC_INIT: begin
                    r_dzero <= (r_dt == '0);
                    r_k     <= (r_dt == '0) ? '0 : r_dt - 1'b1;
                    r_acc   <= DECAY_R[r_env];
                end
                OP_DEC_STEP: begin
                    r_acc <= acc_sum[63:32];
                    r_k   <= r_k - 1'b1;
                end
                OP_DEC_RND: begin
                    r_d <= r_dzero ? 17'h10000 : acc_rnd[32:16];
                end
                OP_PEAK: begin
                    r_peak[r_env] <= peak_new;
                end
                OP_DIV_PUT: begin
                    unique case (i_cmd.dsel)
                        DS_SLEW: begin
                            r_slew[r_env] <= slew_new;
                            if (r_env != ENV_W'(N_ENV - 1)) begin
                                r_env <= r_env + 1'b1;
                            end
                        end
                        DS_MOTION:  r_motion <= r_motion + quo[31:0];
                        DS_ADV:     r_adv    <= r_adv + quo[31:0];
                        DS_FAST:    r_fast   <= fup ? r_fast + quo[15:0] : r_fast - quo[15:0];
                        DS_SLOW:    r_slow   <= sup ? r_slow + quo[15:0] : r_slow - quo[15:0];
                        DS_BEAT: begin
                            if (r_in.tempo_norm > TEMPO_MIN) begin
                                r_beat <= r_beat + quo[15:0];
                            end
                        end
                        DS_BAR_MOD: r_barm <= rem[11:0];
                        DS_BAR:     r_bar  <= quo[15:0];
                        default: begin
                        end
                    endcase
                end
                OP_EMIT: begin
                    r_out.beat_out       <= r_slew[0];
                    r_out.onset_out      <= r_slew[1];
                    r_out.downbeat_out   <= r_slew[2];
                    r_out.kick_out       <= r_slew[3];
                    r_out.snare_out      <= r_slew[4];
                    r_out.hat_out        <= r_slew[5];
                    r_out.motion_phase   <= r_motion;
                    r_out.advance_phase  <= r_adv;
                    r_out.swell_out      <= swell;
                    r_out.beat_phase_out <= r_beat;
                    r_out.bar_phase_out  <= r_bar;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.k_zero   = (r_k == '0);
    assign o_stat.last_env = (r_env == ENV_W'(N_ENV - 1));
    assign o_stat.div_busy = div_busy;
    assign o_stat.out_free = !r_out_vld || !i_out_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ===== hdl/audio_envelope_follower.sv =====
// ----------------------------------------------------------------------------
// audio_envelope_follower
// peak-hold envelopes with slew limiting, phase integrators, swell and bar phase
// ----------------------------------------------------------------------------
// One frame is taken at a time. Each of the six envelopes runs its decay one
// millisecond per cycle through the shared multiplier, dt being the frame
// interval in ms, and thirteen quotients go through one constant divider
// using reciprocal multiplication. The result sits in an output register,
// so a new frame is accepted while the previous result still waits to be
// taken.
module audio_envelope_follower #(
    parameter int MAX_INTERVAL_MS = 250
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  aef_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output aef_pkg::t_out o_out_item
);
    import aef_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    aef_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    aef_dp #(
        .MAX_INTERVAL_MS (MAX_INTERVAL_MS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== dv/aef_checker.sv =====
// ----------------------------------------------------------------------------
// aef_checker
// watches both channels of the envelope follower, predicts every result from
// the accepted frames and compares each result field by field, in order
// ----------------------------------------------------------------------------
module aef_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  aef_pkg::t_in   i_in_item,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  aef_pkg::t_out  i_out_item,
    output int             o_errors,
    output int             o_pending,
    output int             o_checked
);
    import aef_pkg::*;

    localparam int          ENVS      = 6;
    localparam logic [31:0] GAP_LIMIT = 32'd250;
    localparam logic [31:0] FALLBACK_DT = 32'd16;
    localparam logic [15:0] SLOWEST_TEMPO = 16'd262;

    localparam int TAU_MS [ENVS] = '{300, 220, 450, 240, 200, 140};
    localparam int RATE_PS [ENVS] = '{6, 7, 5, 7, 7, 8};

    logic [63:0] per_ms_r [ENVS];
    logic [31:0] prev_time;
    logic [15:0] peak [ENVS];
    logic [15:0] slewed [ENVS];
    logic [31:0] motion;
    logic [31:0] advance;
    logic [15:0] lvl_fast;
    logic [15:0] lvl_slow;
    logic [15:0] beat_ph;
    t_out        frame_results [$];
    int          errors = 0;
    int          checked = 0;

    assign o_errors  = errors;
    assign o_pending = frame_results.size();
    assign o_checked = checked;

    function automatic logic [63:0] series_factor(input int tau);
        logic [63:0] one;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        one  = 64'h1_0000_0000;
        x    = (one + tau / 2) / tau;
        term = one;
        sum  = one;
        for (int n = 1; n <= 4; n++) begin
            term = (term * x) / (64'(n) << 32);
            if (n % 2 == 1) sum = sum - term;
            else            sum = sum + term;
        end
        return sum;
    endfunction

    function automatic logic [31:0] decay_gain(input logic [63:0] r, input logic [31:0] dt);
        logic [63:0] acc;
        acc = 64'h1_0000_0000;
        for (int k = 0; k < dt; k++)
            acc = (acc * r + 64'h8000_0000) >> 32;
        return 32'((acc + 64'd32768) >> 16);
    endfunction

    function automatic logic [15:0] ease(input logic [15:0] cur, input logic [15:0] tgt,
                                         input logic [31:0] dt, input logic [31:0] tc);
        logic [63:0] m;
        logic [63:0] stp;
        m = (dt > tc) ? 64'(tc) : 64'(dt);
        if (tgt >= cur) begin
            stp = (64'(tgt - cur) * m + tc / 2) / tc;
            return cur + 16'(stp);
        end
        stp = (64'(cur - tgt) * m + tc / 2) / tc;
        return cur - 16'(stp);
    endfunction

    task automatic clear_state();
        prev_time = '0;
        for (int i = 0; i < ENVS; i++) begin
            peak[i]   = '0;
            slewed[i] = '0;
        end
        motion   = '0;
        advance  = '0;
        lvl_fast = '0;
        lvl_slow = '0;
        beat_ph  = '0;
    endtask

    task automatic follow_frame(input t_in f);
        logic [31:0] dt;
        logic [15:0] strength [ENVS];
        logic [63:0] scaled;
        logic [63:0] stp;
        logic [63:0] inc;
        logic [15:0] diff;
        int          sw;
        t_out        res;
        strength = '{f.beat_decay, f.onset_strength, f.downbeat_strength,
                     f.kick_strength, f.snare_strength, f.hat_strength};
        if (f.restart) clear_state();
        if (f.time_ms < prev_time || f.time_ms - prev_time > GAP_LIMIT) dt = FALLBACK_DT;
        else dt = f.time_ms - prev_time;
        prev_time = f.time_ms;
        for (int i = 0; i < ENVS; i++) begin
            scaled = (64'(peak[i]) * decay_gain(per_ms_r[i], dt) + 64'd32768) >> 16;
            if (scaled > 64'd65535) scaled = 64'd65535;
            peak[i] = (scaled > 64'(strength[i])) ? 16'(scaled) : strength[i];
            stp = (64'(RATE_PS[i]) * dt * 64'd65536 + 64'd500) / 64'd1000;
            if (peak[i] >= slewed[i]) begin
                diff = peak[i] - slewed[i];
                slewed[i] = slewed[i] + ((64'(diff) > stp) ? 16'(stp) : diff);
            end else begin
                diff = slewed[i] - peak[i];
                slewed[i] = slewed[i] - ((64'(diff) > stp) ? 16'(stp) : diff);
            end
        end
        motion  = motion + 32'(((64'd65536 + 64'd5 * slewed[0] + 64'd3 * f.overall_level)
                                * dt + 64'd5000) / 64'd10000);
        advance = advance + 32'(((64'd196608 + 64'd20 * f.overall_level) * dt + 64'd10000)
                                / 64'd20000);
        lvl_fast = ease(lvl_fast, f.overall_level, dt, 32'd1500);
        lvl_slow = ease(lvl_slow, f.overall_level, dt, 32'd8000);
        sw = (int'(lvl_fast) - int'(lvl_slow)) * 4;
        if (sw < 0) sw = 0;
        if (sw > 65535) sw = 65535;
        if (f.tempo_norm > SLOWEST_TEMPO) begin
            inc = ((64'd2621440 + 64'd160 * f.tempo_norm) * dt + 64'd30000) / 64'd60000;
            beat_ph = beat_ph + 16'(inc);
        end
        res.beat_out       = slewed[0];
        res.onset_out      = slewed[1];
        res.downbeat_out   = slewed[2];
        res.kick_out       = slewed[3];
        res.snare_out      = slewed[4];
        res.hat_out        = slewed[5];
        res.motion_phase   = motion;
        res.advance_phase  = advance;
        res.swell_out      = 16'(sw);
        res.beat_phase_out = beat_ph;
        res.bar_phase_out  = 16'((64'(f.time_ms % 32'd4000) * 64'd65536) / 64'd4000);
        frame_results.push_back(res);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("mismatch on result %0d, %s: expected %0h, got %0h",
                         checked, fname, want, got);
        end
    endtask

    initial begin
        for (int i = 0; i < ENVS; i++) per_ms_r[i] = series_factor(TAU_MS[i]);
        clear_state();
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) follow_frame(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                if (frame_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("result with no frame waiting for it");
                end else begin
                    want = frame_results.pop_front();
                    check_field("beat_out", want.beat_out, i_out_item.beat_out);
                    check_field("onset_out", want.onset_out, i_out_item.onset_out);
                    check_field("downbeat_out", want.downbeat_out, i_out_item.downbeat_out);
                    check_field("kick_out", want.kick_out, i_out_item.kick_out);
                    check_field("snare_out", want.snare_out, i_out_item.snare_out);
                    check_field("hat_out", want.hat_out, i_out_item.hat_out);
                    check_field("motion_phase", want.motion_phase, i_out_item.motion_phase);
                    check_field("advance_phase", want.advance_phase,
                                i_out_item.advance_phase);
                    check_field("swell_out", want.swell_out, i_out_item.swell_out);
                    check_field("beat_phase_out", want.beat_phase_out,
                                i_out_item.beat_phase_out);
                    check_field("bar_phase_out", want.bar_phase_out,
                                i_out_item.bar_phase_out);
                    checked++;
                end
            end
        end
    end

endmodule

// ===== dv/tb_audio_envelope_follower.sv =====
// ----------------------------------------------------------------------------
// tb_audio_envelope_follower
// drives directed frames, then random frames of audio features into the
// envelope follower, with random gaps and output stalls in part of the run;
// a checker beside the block predicts and compares
module tb_audio_envelope_follower;
    import aef_pkg::*;

    localparam int  RANDOM_FRAMES = 1600;
    localparam int  DRAIN_CYCLES  = 2200;
    localparam longint CYCLE_LIMIT = 64'd12_000_000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    t_in    in_item = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    t_out   out_item;
    int     errors;
    int     pending;
    int     checked;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     frames_sent = 0;
    longint cycles = 0;
    logic [31:0] clock_ms = '0;

    audio_envelope_follower dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    aef_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [15:0] pick_q16();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(300));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(input t_in f);
        in_item  <= f;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        frames_sent++;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_at(input logic rst, input logic [31:0] t, input logic [15:0] s,
                           input logic [15:0] lvl, input logic [15:0] tempo);
        t_in f;
        f = '{rst, t, s, s, s, s, s, s, lvl, tempo};
        send_frame(f);
    endtask

    task automatic random_frame();
        t_in f;
        int  r;
        r = $urandom_range(99);
        f.restart = 1'b0;
        if (r < 3) begin
            f.restart = 1'b1;
            clock_ms  = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(400));
        end else if (r < 6) begin
            clock_ms = clock_ms - 32'($urandom_range(1, 1000));
        end else if (r < 10) begin
            clock_ms = clock_ms + 32'($urandom_range(251, 100000));
        end else if (r < 13) begin
            clock_ms = clock_ms;
        end else if (r < 15) begin
            clock_ms = clock_ms + 32'd250;
        end else if (r < 16) begin
            clock_ms = 32'hffff_ff00 + 32'($urandom_range(255));
        end else if (r < 17) begin
            clock_ms = $urandom;
        end else begin
            clock_ms = clock_ms + 32'($urandom_range(1, 33));
        end
        f.time_ms           = clock_ms;
        f.beat_decay        = pick_q16();
        f.onset_strength    = pick_q16();
        f.downbeat_strength = pick_q16();
        f.kick_strength     = pick_q16();
        f.snare_strength    = pick_q16();
        f.hat_strength      = pick_q16();
        f.overall_level     = pick_q16();
        f.tempo_norm        = ($urandom_range(7) == 0) ? 16'(261 + $urandom_range(3))
                                                       : pick_q16();
        send_frame(f);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero interval, extremes, tempo threshold, gap limits, wrap, restarts
        send_at(1'b0, 32'd0, 16'hffff, 16'hffff, 16'hffff);
        send_at(1'b0, 32'd0, 16'h0000, 16'h0000, 16'd262);
        send_at(1'b0, 32'd16, 16'h0000, 16'hffff, 16'd263);
        send_at(1'b0, 32'd266, 16'h8000, 16'hffff, 16'd0);
        send_at(1'b0, 32'd517, 16'h0000, 16'h0000, 16'hffff);
        send_at(1'b0, 32'd500, 16'h1234, 16'h0000, 16'h8000);
        send_at(1'b0, 32'd3999, 16'hffff, 16'h4000, 16'hffff);
        send_at(1'b0, 32'd4000, 16'h0000, 16'hffff, 16'd262);
        send_at(1'b0, 32'd4001, 16'h0000, 16'h0000, 16'h0001);
        send_at(1'b0, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff);
        send_at(1'b0, 32'hffff_ffff, 16'h0001, 16'h0001, 16'hfffe);
        send_at(1'b0, 32'd5, 16'h0000, 16'h0000, 16'hffff);
        send_at(1'b1, 32'd0, 16'hffff, 16'hffff, 16'h5555);
        send_at(1'b1, 32'd250, 16'haaaa, 16'h5555, 16'haaaa);
        for (int i = 0; i < 6; i++)
            send_at(1'b0, 32'd260 + 32'(i) * 32'd40, 16'h0000, 16'h0000, 16'h7fff);
        clock_ms = 32'd500;

        // hold off until the block has drained
        in_valid <= 1'b0;
        wait (pending == 0);
        @(posedge i_clk);

        send_idle_pct = 19;
        recv_idle_pct = 64;
        for (int i = 0; i < RANDOM_FRAMES / 3; i++) random_frame();
        send_idle_pct = 64;
        recv_idle_pct = 19;
        for (int i = 0; i < RANDOM_FRAMES / 3; i++) random_frame();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < RANDOM_FRAMES - 2 * (RANDOM_FRAMES / 3); i++) random_frame();
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d frames, checked %0d results over %0d cycles", frames_sent,
                 checked, cycles);
        $display("covered restarts, backward and long gaps, zero interval and tempo floor");
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
